// ===== hw/rtl/amr_pkg.sv =====
// Shared constants and types for the accelerometer/magnetometer rotation unit.
package amr_pkg;

  // Output component width and saturation magnitude.
  localparam int          OUT_W    = 16;
  localparam logic [15:0] OUT_MAX  = 16'd32767;

  // Width of the degenerate-norm threshold register.
  localparam int          CFG_W    = 31;

  // Rotation matrix components: north x/y/z, east x/y/z, up x/y/z.
  localparam int          NUM_COMP = 9;

  // Per-item side information that travels next to the datapath.
  typedef struct packed {
    logic                degen;
    logic [NUM_COMP-1:0] neg;
  } amr_side_t;

endpackage

// ===== hw/rtl/amr_pipe_ctrl.sv =====
// Valid tracking and per-stage load enables for the rotation pipeline.
module amr_pipe_ctrl #(
  parameter int NS = 22
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [NS-1:0] en_o
);

  localparam logic [NS-1:0] ONES = '1;

  logic [NS-1:0] valid_q;

  // A stage may load when any stage from it to the output holds a bubble,
  // or the output transaction completes, so bubbles collapse under a stall.
  always_comb begin
    for (int i = 0; i < NS; i++) begin
      en_o[i] = out_ready_i || ((valid_q >> i) != (ONES >> i));
    end
  end

  // Valid bits shift along with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (en_o[i]) begin
          valid_q[i] <= (i == 0) ? in_valid_i : valid_q[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  assign in_ready_o  = en_o[0];
  assign out_valid_o = valid_q[NS-1];

  // An accepted transaction occupies the first stage on the next cycle.
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> valid_q[0])
    else $error("accepted transaction did not enter the first stage");

  // A completely full pipeline with a stalled output takes nothing new.
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&valid_q) && !out_ready_i |-> !in_ready_o)
    else $error("full pipeline accepted a transaction under stall");

  // A delivered result with a bubble behind it leaves the output empty.
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[NS-1] && out_ready_i && !valid_q[NS-2] |=> !valid_q[NS-1])
    else $error("delivered result was repeated");

endmodule

// ===== hw/rtl/amr_vec_front.sv =====
// Front datapath: dot and cross products, Gram-Schmidt north, norms and squares.
module amr_vec_front #(
  parameter int S = 16
) (
  input  logic                           clk_i,
  input  logic [5:0]                     en_i,
  input  logic [amr_pkg::CFG_W-1:0]      thr_i,
  input  logic signed [S-1:0]            acc_i  [3],
  input  logic signed [S-1:0]            mag_i  [3],
  output logic [6*S-1:0]                 norm_o [3],
  output logic [6*S-1:0]                 mag2_o [amr_pkg::NUM_COMP],
  output amr_pkg::amr_side_t             side_o
);

  import amr_pkg::*;

  localparam int P2  = 2 * S;        // product of two samples
  localparam int CW  = 2 * S + 1;    // cross product component
  localparam int NWD = 3 * S + 1;    // north component before normalizing
  localparam int QW  = 4 * S;        // squared cross product
  localparam int HW  = 6 * S;        // squared north magnitude
  localparam int TW  = 2 * S + CFG_W;
  localparam int LOB = (3 * S + 1) / 2;

  // Stage 1: all sample products.
  logic signed [S-1:0]  a1_q  [3];
  logic signed [S-1:0]  m1_q  [3];
  logic signed [P2-1:0] aa1_q [3];
  logic signed [P2-1:0] mm1_q [3];
  logic signed [P2-1:0] am1_q [3];
  logic signed [P2-1:0] cr1_q [6];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int i = 0; i < 3; i++) begin
        a1_q[i]  <= acc_i[i];
        m1_q[i]  <= mag_i[i];
        aa1_q[i] <= acc_i[i] * acc_i[i];
        mm1_q[i] <= mag_i[i] * mag_i[i];
        am1_q[i] <= acc_i[i] * mag_i[i];
      end
      cr1_q[0] <= acc_i[1] * mag_i[2];
      cr1_q[1] <= acc_i[2] * mag_i[1];
      cr1_q[2] <= acc_i[2] * mag_i[0];
      cr1_q[3] <= acc_i[0] * mag_i[2];
      cr1_q[4] <= acc_i[0] * mag_i[1];
      cr1_q[5] <= acc_i[1] * mag_i[0];
    end
  end

  // Stage 2: squared norms, a.m and the cross product.
  logic [P2+1:0]          aa_sum;
  logic [P2+1:0]          mm_sum;
  logic [P2-1:0]          aa2_q;
  logic [P2-1:0]          mm2_q;
  logic signed [CW-1:0]   am2_q;
  logic signed [CW-1:0]   c2_q   [3];
  logic signed [S-1:0]    a2_q   [3];
  logic signed [S-1:0]    m2_q   [3];
  logic signed [P2-1:0]   asq2_q [3];

  always_comb begin
    aa_sum = (P2+2)'($unsigned(aa1_q[0])) + (P2+2)'($unsigned(aa1_q[1]))
           + (P2+2)'($unsigned(aa1_q[2]));
    mm_sum = (P2+2)'($unsigned(mm1_q[0])) + (P2+2)'($unsigned(mm1_q[1]))
           + (P2+2)'($unsigned(mm1_q[2]));
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      aa2_q   <= aa_sum[P2-1:0];
      mm2_q   <= mm_sum[P2-1:0];
      am2_q   <= am1_q[0] + am1_q[1] + am1_q[2];
      c2_q[0] <= cr1_q[0] - cr1_q[1];
      c2_q[1] <= cr1_q[2] - cr1_q[3];
      c2_q[2] <= cr1_q[4] - cr1_q[5];
      for (int i = 0; i < 3; i++) begin
        a2_q[i]   <= a1_q[i];
        m2_q[i]   <= m1_q[i];
        asq2_q[i] <= aa1_q[i];
      end
    end
  end

  // Stage 3: squares of the cross product, threshold product, north terms.
  logic signed [2*CW-1:0] csq_full [3];
  logic [QW-1:0]          csq3_q   [3];
  logic [TW-1:0]          ta3_q;
  logic                   small3_q;
  logic signed [NWD-1:0]  na3_q    [3];
  logic signed [NWD-1:0]  nb3_q    [3];
  logic [P2-1:0]          aa3_q;
  logic signed [P2-1:0]   asq3_q   [3];
  logic [2:0]             cneg3_q;
  logic [2:0]             aneg3_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      csq_full[i] = c2_q[i] * c2_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      ta3_q    <= thr_i * aa2_q;
      small3_q <= (aa2_q < thr_i) || (mm2_q < thr_i);
      aa3_q    <= aa2_q;
      for (int i = 0; i < 3; i++) begin
        csq3_q[i]  <= csq_full[i][QW-1:0];
        na3_q[i]   <= $signed({1'b0, aa2_q}) * m2_q[i];
        nb3_q[i]   <= am2_q * a2_q[i];
        asq3_q[i]  <= asq2_q[i];
        cneg3_q[i] <= c2_q[i][CW-1];
        aneg3_q[i] <= a2_q[i][S-1];
      end
    end
  end

  // Stage 4: |a x m|^2, north vector and the degenerate decision.
  logic [QW+1:0]         cc_sum;
  logic [QW-1:0]         cc4_q;
  logic signed [NWD-1:0] n4_q   [3];
  logic                  degen4_q;
  logic [P2-1:0]         aa4_q;
  logic [QW-1:0]         csq4_q [3];
  logic signed [P2-1:0]  asq4_q [3];
  logic [2:0]            cneg4_q;
  logic [2:0]            aneg4_q;

  always_comb begin
    cc_sum = (QW+2)'(csq3_q[0]) + (QW+2)'(csq3_q[1]) + (QW+2)'(csq3_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      cc4_q    <= cc_sum[QW-1:0];
      degen4_q <= small3_q || (cc_sum < (QW+2)'(ta3_q));
      aa4_q    <= aa3_q;
      cneg4_q  <= cneg3_q;
      aneg4_q  <= aneg3_q;
      for (int i = 0; i < 3; i++) begin
        n4_q[i]   <= na3_q[i] - nb3_q[i];
        csq4_q[i] <= csq3_q[i];
        asq4_q[i] <= asq3_q[i];
      end
    end
  end

  // Stage 5: partial products of |north|^2 and of the north norm.
  logic signed [NWD-1:0] nabs   [3];
  logic [3*S-1:0]        nmag   [3];
  logic [HW-1:0]         hh5_q  [3];
  logic [HW-1:0]         hl5_q  [3];
  logic [HW-1:0]         ll5_q  [3];
  logic [QW-1:0]         plo5_q;
  logic [QW-1:0]         phi5_q;
  logic [QW-1:0]         cc5_q;
  logic [P2-1:0]         aa5_q;
  logic [QW-1:0]         csq5_q [3];
  logic signed [P2-1:0]  asq5_q [3];
  logic [2:0]            nneg5_q;
  logic [2:0]            cneg5_q;
  logic [2:0]            aneg5_q;
  logic                  degen5_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nabs[i] = n4_q[i][NWD-1] ? -n4_q[i] : n4_q[i];
      nmag[i] = nabs[i][3*S-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      plo5_q   <= cc4_q[P2-1:0] * aa4_q;
      phi5_q   <= cc4_q[QW-1:P2] * aa4_q;
      cc5_q    <= cc4_q;
      aa5_q    <= aa4_q;
      cneg5_q  <= cneg4_q;
      aneg5_q  <= aneg4_q;
      degen5_q <= degen4_q;
      for (int i = 0; i < 3; i++) begin
        hh5_q[i]   <= nmag[i][3*S-1:LOB] * nmag[i][3*S-1:LOB];
        hl5_q[i]   <= nmag[i][3*S-1:LOB] * nmag[i][LOB-1:0];
        ll5_q[i]   <= nmag[i][LOB-1:0] * nmag[i][LOB-1:0];
        nneg5_q[i] <= n4_q[i][NWD-1];
        csq5_q[i]  <= csq4_q[i];
        asq5_q[i]  <= asq4_q[i];
      end
    end
  end

  // Stage 6: combine partial products into the final norms and squares.
  logic [HW-1:0]        nn6_q;
  logic [HW-1:0]        nsq6_q [3];
  logic [QW-1:0]        cc6_q;
  logic [P2-1:0]        aa6_q;
  logic [QW-1:0]        csq6_q [3];
  logic signed [P2-1:0] asq6_q [3];
  logic [2:0]           nneg6_q;
  logic [2:0]           cneg6_q;
  logic [2:0]           aneg6_q;
  logic                 degen6_q;

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      nn6_q    <= (HW'(phi5_q) << P2) + HW'(plo5_q);
      cc6_q    <= cc5_q;
      aa6_q    <= aa5_q;
      nneg6_q  <= nneg5_q;
      cneg6_q  <= cneg5_q;
      aneg6_q  <= aneg5_q;
      degen6_q <= degen5_q;
      for (int i = 0; i < 3; i++) begin
        nsq6_q[i] <= (hh5_q[i] << (2 * LOB)) + (hl5_q[i] << (LOB + 1)) + ll5_q[i];
        csq6_q[i] <= csq5_q[i];
        asq6_q[i] <= asq5_q[i];
      end
    end
  end

  // Hand the three vectors to the normalizers: north, east, up.
  always_comb begin
    norm_o[0] = nn6_q;
    norm_o[1] = HW'(cc6_q);
    norm_o[2] = HW'(aa6_q);
    for (int i = 0; i < 3; i++) begin
      mag2_o[i]     = nsq6_q[i];
      mag2_o[3 + i] = HW'(csq6_q[i]);
      mag2_o[6 + i] = HW'($unsigned(asq6_q[i]));
      side_o.neg[i]     = nneg6_q[i];
      side_o.neg[3 + i] = cneg6_q[i];
      side_o.neg[6 + i] = aneg6_q[i];
    end
    side_o.degen = degen6_q;
  end

endmodule

// ===== hw/rtl/amr_unit_norm.sv =====
// Pipelined bit-per-stage search for one rounded unit vector component.
module amr_unit_norm #(
  parameter int NW = 96,
  parameter int F  = 14
) (
  input  logic          clk_i,
  input  logic [F:0]    en_i,
  input  logic          neg_i,
  input  logic [NW-1:0] norm_i,
  input  logic [NW-1:0] mag2_i,
  output logic [F:0]    k_o,
  output logic          neg_o
);

  // The trial value (2k-1)^2 * N is kept incrementally together with
  // (2k-1) * N, so each stage needs only shifted adds and one compare.
  localparam int LW = NW + 2 * F + 5;
  localparam int KW = F + 1;

  logic [LW-1:0] lhs_in [F+1];
  logic [LW-1:0] q_in   [F+1];
  logic [LW-1:0] n_in   [F+1];
  logic [LW-1:0] m_in   [F+1];
  logic [KW-1:0] k_in   [F+1];
  logic          neg_in [F+1];
  logic [LW-1:0] lhs_t  [F+1];
  logic          take   [F+1];

  logic [LW-1:0] lhs_q  [F+1];
  logic [LW-1:0] q_q    [F+1];
  logic [LW-1:0] n_q    [F+1];
  logic [LW-1:0] m_q    [F+1];
  logic [KW-1:0] k_q    [F+1];
  logic          neg_q  [F+1];

  for (genvar j = 0; j <= F; j++) begin : g_stage
    localparam int B = F - j;

    // Stage zero starts from k = 0, where 2k-1 is minus one.
    if (j == 0) begin : g_first
      assign lhs_in[j] = LW'(norm_i);
      assign q_in[j]   = -LW'(norm_i);
      assign n_in[j]   = LW'(norm_i);
      assign m_in[j]   = LW'(mag2_i) << (2 * F + 2);
      assign k_in[j]   = '0;
      assign neg_in[j] = neg_i;
    end else begin : g_next
      assign lhs_in[j] = lhs_q[j-1];
      assign q_in[j]   = q_q[j-1];
      assign n_in[j]   = n_q[j-1];
      assign m_in[j]   = m_q[j-1];
      assign k_in[j]   = k_q[j-1];
      assign neg_in[j] = neg_q[j-1];
    end

    // Try setting bit B of k and keep it if the square still fits.
    assign lhs_t[j] = lhs_in[j] + (q_in[j] << (B + 2)) + (n_in[j] << (2 * B + 2));
    assign take[j]  = (lhs_t[j] <= m_in[j]);

    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        lhs_q[j] <= take[j] ? lhs_t[j] : lhs_in[j];
        q_q[j]   <= take[j] ? (q_in[j] + (n_in[j] << (B + 1))) : q_in[j];
        k_q[j]   <= take[j] ? (k_in[j] | (KW'(1) << B)) : k_in[j];
        n_q[j]   <= n_in[j];
        m_q[j]   <= m_in[j];
        neg_q[j] <= neg_in[j];
      end
    end
  end

  assign k_o   = k_q[F];
  assign neg_o = neg_q[F];

endmodule

// ===== hw/rtl/accel_mag_to_neu_rotation_unit.sv =====
// Top level of the accelerometer/magnetometer to north-east-up rotation unit.
//
//   channel   direction  handshake                 payload
//   in        input      in_valid_i / in_ready_o   accel_{x,y,z}_i, mag_{x,y,z}_i
//   out       output     out_valid_o / out_ready_i {north,east,up}_d{x,y,z}_o,
//                                                  result_valid_o
//   cfg       input      cfg_valid_i / cfg_ready_o cfg_data_i (min_norm_squared)
//
// One transaction enters per cycle while in_ready_o is high; the pipeline
// has six product/norm stages, one normalizer stage per result bit, and the
// output register. Reset clears the valid bits and sets the threshold to
// one. Under an output stall, stages with bubbles keep loading until the
// pipeline is full; nothing is dropped or repeated.
module accel_mag_to_neu_rotation_unit #(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 14
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [15:0]                 accel_x_i,
  input  logic signed [15:0]                 accel_y_i,
  input  logic signed [15:0]                 accel_z_i,
  input  logic signed [15:0]                 mag_x_i,
  input  logic signed [15:0]                 mag_y_i,
  input  logic signed [15:0]                 mag_z_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [amr_pkg::OUT_W-1:0]   north_dx_o,
  output logic signed [amr_pkg::OUT_W-1:0]   north_dy_o,
  output logic signed [amr_pkg::OUT_W-1:0]   north_dz_o,
  output logic signed [amr_pkg::OUT_W-1:0]   east_dx_o,
  output logic signed [amr_pkg::OUT_W-1:0]   east_dy_o,
  output logic signed [amr_pkg::OUT_W-1:0]   east_dz_o,
  output logic signed [amr_pkg::OUT_W-1:0]   up_dx_o,
  output logic signed [amr_pkg::OUT_W-1:0]   up_dy_o,
  output logic signed [amr_pkg::OUT_W-1:0]   up_dz_o,
  output logic                               result_valid_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [amr_pkg::CFG_W-1:0]          cfg_data_i
);

  import amr_pkg::*;

  localparam int S    = SAMPLE_BITS;
  localparam int F    = FRAC_BITS;
  localparam int NS   = F + 8;
  localparam int HW   = 6 * S;
  localparam int EW   = (S > 16) ? S : 16;
  localparam int KW2  = (F + 1 > 16) ? F + 1 : 16;
  localparam logic [OUT_W-1:0] ONE = (F >= 15) ? OUT_MAX : OUT_W'(1 << F);

  // Threshold register; zero behaves as one.
  logic [CFG_W-1:0] thr_q;
  logic [CFG_W-1:0] thr_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= CFG_W'(1);
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign thr_eff     = (thr_q == '0) ? CFG_W'(1) : thr_q;

  // Take the low sample bits of each input, sign-extended.
  logic signed [EW-1:0] in_ext [6];
  logic signed [S-1:0]  acc_s  [3];
  logic signed [S-1:0]  mag_s  [3];

  always_comb begin
    in_ext[0] = EW'(accel_x_i);
    in_ext[1] = EW'(accel_y_i);
    in_ext[2] = EW'(accel_z_i);
    in_ext[3] = EW'(mag_x_i);
    in_ext[4] = EW'(mag_y_i);
    in_ext[5] = EW'(mag_z_i);
    for (int i = 0; i < 3; i++) begin
      acc_s[i] = in_ext[i][S-1:0];
      mag_s[i] = in_ext[3 + i][S-1:0];
    end
  end

  // Pipeline control.
  logic [NS-1:0] en;

  amr_pipe_ctrl #(.NS(NS)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .en_o        (en)
  );

  // Products, norms and squares.
  logic [HW-1:0] norm [3];
  logic [HW-1:0] mag2 [NUM_COMP];
  amr_side_t     side;

  amr_vec_front #(.S(S)) u_front (
    .clk_i  (clk_i),
    .en_i   (en[5:0]),
    .thr_i  (thr_eff),
    .acc_i  (acc_s),
    .mag_i  (mag_s),
    .norm_o (norm),
    .mag2_o (mag2),
    .side_o (side)
  );

  // One normalizer per matrix component.
  logic [F:0]         k    [NUM_COMP];
  logic [NUM_COMP-1:0] kneg;

  for (genvar c = 0; c < NUM_COMP; c++) begin : g_comp
    amr_unit_norm #(.NW(HW), .F(F)) u_norm (
      .clk_i  (clk_i),
      .en_i   (en[F+6:6]),
      .neg_i  (side.neg[c]),
      .norm_i (norm[c / 3]),
      .mag2_i (mag2[c]),
      .k_o    (k[c]),
      .neg_o  (kneg[c])
    );
  end

  // Degenerate flag rides alongside the normalizer stages.
  logic degen_q [F+1];

  always_ff @(posedge clk_i) begin
    for (int j = 0; j <= F; j++) begin
      if (en[6 + j]) begin
        degen_q[j] <= (j == 0) ? side.degen : degen_q[(j == 0) ? 0 : j - 1];
      end
    end
  end

  // Output register: saturate, apply sign, or substitute the identity.
  logic [KW2-1:0]   kx   [NUM_COMP];
  logic [OUT_W-1:0] kmag [NUM_COMP];
  logic [OUT_W-1:0] comp_q [NUM_COMP];
  logic             rv_q;

  always_comb begin
    for (int c = 0; c < NUM_COMP; c++) begin
      kx[c]   = KW2'(k[c]);
      kmag[c] = (kx[c] > KW2'(OUT_MAX)) ? OUT_MAX : kx[c][OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NS-1]) begin
      rv_q <= !degen_q[F];
      for (int c = 0; c < NUM_COMP; c++) begin
        if (degen_q[F]) begin
          comp_q[c] <= (c == 0 || c == 4 || c == 8) ? ONE : '0;
        end else begin
          comp_q[c] <= kneg[c] ? -kmag[c] : kmag[c];
        end
      end
    end
  end

  assign north_dx_o     = comp_q[0];
  assign north_dy_o     = comp_q[1];
  assign north_dz_o     = comp_q[2];
  assign east_dx_o      = comp_q[3];
  assign east_dy_o      = comp_q[4];
  assign east_dz_o      = comp_q[5];
  assign up_dx_o        = comp_q[6];
  assign up_dy_o        = comp_q[7];
  assign up_dz_o        = comp_q[8];
  assign result_valid_o = rv_q;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the accelerometer/magnetometer to north-east-up rotation unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [255:0] wide_t;
  typedef logic [5:0][15:0] sample_set_t;
  typedef struct packed {
    logic [8:0][15:0] comp;
    logic             ok;
  } rotation_t;

  localparam int    FRAC       = 14;
  localparam int    LATENCY    = FRAC + 8;
  localparam int    WATCHDOG   = 4000;
  localparam int    LONG_HOLD  = 90;
  localparam logic [15:0] UNIT_ONE = 16'sd16384;

  logic clk, rst_n;
  logic in_valid, in_ready;
  logic signed [15:0] accel_x, accel_y, accel_z, mag_x, mag_y, mag_z;
  logic out_valid, out_ready;
  logic signed [15:0] north_dx, north_dy, north_dz, east_dx, east_dy, east_dz;
  logic signed [15:0] up_dx, up_dy, up_dz;
  logic result_valid;
  logic cfg_valid, cfg_ready;
  logic [amr_pkg::CFG_W-1:0] cfg_data;

  sample_set_t samples_to_send[$];
  rotation_t   rotations_due[$];
  logic [30:0] threshold_copy;
  int          mismatch_count;
  int          idle_watch;
  logic        in_fire, out_fire;
  logic        idle_enable;
  logic        hold_request;
  int          in_gap, out_gap, hold_left;
  int          results_seen;

  accel_mag_to_neu_rotation_unit i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .accel_x_i     (accel_x),
    .accel_y_i     (accel_y),
    .accel_z_i     (accel_z),
    .mag_x_i       (mag_x),
    .mag_y_i       (mag_y),
    .mag_z_i       (mag_z),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .north_dx_o    (north_dx),
    .north_dy_o    (north_dy),
    .north_dz_o    (north_dz),
    .east_dx_o     (east_dx),
    .east_dy_o     (east_dy),
    .east_dz_o     (east_dz),
    .up_dx_o       (up_dx),
    .up_dy_o       (up_dy),
    .up_dz_o       (up_dz),
    .result_valid_o(result_valid),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // One component of a unit vector: round(v * 2^FRAC / sqrt(norm2)), ties away from zero.
  function automatic logic [15:0] unit_part(wide_t v, wide_t norm2);
    wide_t mag, rhs, lhs, odd, trial;
    wide_t k;
    mag = (v < 0) ? -v : v;
    rhs = mag * mag * (wide_t'(1) <<< (2 * FRAC + 2));
    k = 0;
    for (int b = FRAC; b >= 0; b--) begin
      trial = k | (wide_t'(1) <<< b);
      odd = 2 * trial - 1;
      lhs = odd * odd * norm2;
      if (lhs <= rhs) k = trial;
    end
    if (k > 32767) k = 32767;
    if (v < 0) k = -k;
    return k[15:0];
  endfunction

  // Expected rotation matrix for one accelerometer/magnetometer pair.
  function automatic rotation_t predict_rotation(sample_set_t s, logic [30:0] thr_reg);
    wide_t a[3], m[3], c[3], n[3];
    wide_t aa, mm, cc, am, nn, thr;
    rotation_t r;
    for (int i = 0; i < 3; i++) begin
      a[i] = wide_t'($signed(s[i]));
      m[i] = wide_t'($signed(s[3 + i]));
    end
    thr = (thr_reg == 0) ? wide_t'(1) : wide_t'({1'b0, thr_reg});
    aa = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
    mm = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    c[0] = a[1] * m[2] - a[2] * m[1];
    c[1] = a[2] * m[0] - a[0] * m[2];
    c[2] = a[0] * m[1] - a[1] * m[0];
    cc = c[0] * c[0] + c[1] * c[1] + c[2] * c[2];
    r = '0;
    if (aa < thr || mm < thr || cc < thr * aa) begin
      r.comp[0] = UNIT_ONE;
      r.comp[4] = UNIT_ONE;
      r.comp[8] = UNIT_ONE;
      return r;
    end
    am = a[0] * m[0] + a[1] * m[1] + a[2] * m[2];
    nn = cc * aa;
    for (int i = 0; i < 3; i++) begin
      n[i] = aa * m[i] - am * a[i];
      r.comp[i]     = unit_part(n[i], nn);
      r.comp[3 + i] = unit_part(c[i], cc);
      r.comp[6 + i] = unit_part(a[i], aa);
    end
    r.ok = 1'b1;
    return r;
  endfunction

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH result %0d %s: got %0d expected %0d", results_seen, what, got, want);
    mismatch_count++;
  endtask

  // Handshake sampling, prediction and checking at the rising edge.
  always @(posedge clk) begin
    rotation_t want;
    logic [8:0][15:0] got;
    in_fire  <= in_valid && in_ready;
    out_fire <= out_valid && out_ready;
    if (in_valid && in_ready) begin
      rotations_due.push_back(predict_rotation({mag_z, mag_y, mag_x, accel_z, accel_y, accel_x},
                                               threshold_copy));
    end
    if (out_valid && out_ready) begin
      got = {up_dz, up_dy, up_dx, east_dz, east_dy, east_dx, north_dz, north_dy, north_dx};
      if (rotations_due.size() == 0) begin
        report_mismatch("unexpected transaction", 0, 0);
      end else begin
        want = rotations_due.pop_front();
        for (int i = 0; i < 9; i++) begin
          if (got[i] !== want.comp[i]) begin
            report_mismatch($sformatf("component %0d", i), $signed(got[i]),
                            $signed(want.comp[i]));
          end
        end
        if (result_valid !== want.ok) report_mismatch("result_valid", result_valid, want.ok);
      end
      results_seen++;
    end
    // Watchdog: count cycles with work outstanding but no transaction.
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) ||
        (samples_to_send.size() == 0 && rotations_due.size() == 0 && !in_valid && !cfg_valid)) begin
      idle_watch = 0;
    end else begin
      idle_watch++;
      if (idle_watch >= WATCHDOG) begin
        $display("Timeout: no transaction for %0d cycles", WATCHDOG);
        $display("** accel_mag_to_neu_rotation_unit: FAILED **");
        $finish;
      end
    end
  end

  // Input driver: pops queued sample pairs, inserts random gaps.
  always @(negedge clk) begin
    sample_set_t s;
    if (rst_n && (!in_valid || in_fire)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (samples_to_send.size() > 0) begin
        s = samples_to_send.pop_front();
        {mag_z, mag_y, mag_x, accel_z, accel_y, accel_x} <= s;
        in_valid <= 1'b1;
        in_gap = idle_enable ? $urandom_range(0, 5) : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output receiver: random stalls, and a long hold-off on request.
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_request && hold_left == 0) begin
        hold_left = LONG_HOLD;
        hold_request = 1'b0;
      end
      if (out_fire) out_gap = idle_enable ? $urandom_range(0, 5) : 0;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Random sample pair of a chosen flavor.
  function automatic sample_set_t random_pair();
    sample_set_t s;
    int flavor;
    int lim;
    flavor = $urandom_range(0, 9);
    for (int i = 0; i < 6; i++) s[i] = $urandom();
    if (flavor == 0 || flavor == 1) begin
      // Small vectors, near the threshold.
      lim = (flavor == 0) ? 3 : 200;
      for (int i = 0; i < 6; i++) s[i] = $urandom_range(0, 2 * lim) - lim;
    end else if (flavor == 2 || flavor == 3) begin
      // Magnetometer nearly parallel to the accelerometer.
      for (int i = 0; i < 3; i++) begin
        s[i] = $urandom_range(0, 32000) - 16000;
        s[3 + i] = $signed(s[i]) * (flavor == 2 ? 1 : -2) + $urandom_range(0, 6) - 3;
      end
    end else if (flavor == 4) begin
      // Realistic gravity and field magnitudes.
      for (int i = 0; i < 6; i++) s[i] = $urandom_range(0, 8000) - 4000;
    end
    return s;
  endfunction

  // Writes the threshold register while the block is idle.
  task automatic write_threshold(logic [30:0] value);
    @(negedge clk);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    threshold_copy = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every queued pair has been checked, then for the latency.
  task automatic drain();
    while (samples_to_send.size() > 0 || in_valid || rotations_due.size() > 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Stimulus sequence and end of test.
  initial begin
    logic [30:0] settings[6];
    sample_set_t s;
    settings = '{31'd0, 31'h7FFF_FFFF, 31'd1000, 31'd1 << 20, 31'd40000, 31'd1};
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    {accel_x, accel_y, accel_z, mag_x, mag_y, mag_z} = '0;
    threshold_copy = 31'd1;
    mismatch_count = 0;
    idle_watch = 0;
    results_seen = 0;
    in_gap = 0;
    out_gap = 0;
    hold_left = 0;
    hold_request = 1'b0;
    idle_enable = 1'b1;
    in_fire = 1'b0;
    out_fire = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed pairs at reset threshold: zeros, extremes, parallel, orthogonal.
    samples_to_send.push_back('0);
    samples_to_send.push_back({16'sd100, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
    samples_to_send.push_back({16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0});
    samples_to_send.push_back({16'sd0, 16'sd0, 16'sd16384, 16'sd16384, 16'sd0, 16'sd0});
    samples_to_send.push_back({16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd0, 16'sd0});
    samples_to_send.push_back({16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd1});
    samples_to_send.push_back({3{16'h8000}} | 96'h0);
    samples_to_send.push_back({16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF});
    samples_to_send.push_back({16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
    samples_to_send.push_back({16'h8000, 16'h0, 16'h0, 16'h0, 16'h8000, 16'h0});
    samples_to_send.push_back({16'sd0, 16'sd3, 16'sd4, 16'sd0, 16'sd0, 16'sd5});
    samples_to_send.push_back({16'sd2, 16'sd2, 16'sd2, 16'sd1, 16'sd1, 16'sd1});
    samples_to_send.push_back({16'sd1, 16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd0});
    samples_to_send.push_back({16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h0, 16'h7FFF});
    samples_to_send.push_back({16'hFFFF, 16'h0, 16'h0, 16'h0, 16'h0, 16'hFFFF});
    drain();

    // Random phases, one per threshold setting, with and without idling.
    for (int p = 0; p < 6; p++) begin
      write_threshold(settings[p]);
      idle_enable = (p != 2);
      for (int i = 0; i < 140; i++) samples_to_send.push_back(random_pair());
      if (p == 3) begin
        // Long output hold-off while the input keeps offering pairs.
        idle_enable = 1'b0;
        hold_request = 1'b1;
      end
      drain();
    end

    if (mismatch_count == 0) begin
      $display("** accel_mag_to_neu_rotation_unit: PASSED **");
    end else begin
      $display("** accel_mag_to_neu_rotation_unit: FAILED **");
    end
    $finish;
  end

endmodule
